>>> hdl/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared assertion forms for the checker of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_WIDTH   = 64;
    localparam int CNT_WIDTH   = 7;

    localparam logic [2:0] OP_REDUCE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic load;      // capture the input beat and split values
        logic mult;      // form the products
        logic combine;   // add or subtract the cross terms
        logic gcd_start; // seed the GCD unit
        logic gcd_step;  // one binary GCD step
        logic div_start; // seed the divider with the numerator
        logic div_step;  // one restoring division bit
        logic div_save;  // keep the quotient, start on the denominator
        logic finish;    // form the result beat
    } rau_cmd_t;

    typedef struct packed {
        logic zero_den;  // a denominator in use is zero
        logic num_zero;  // result numerator is zero
        logic gcd_done;
        logic div_done;
    } rau_status_t;

endpackage

>>> hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact add, subtract, multiply, divide or reduce of two fractions.
// ----------------------------------------------------------------------------
// Each input beat carries an operation and two fractions; one result beat
// follows with the numerator and positive denominator in lowest terms and a
// status (ok, zero denominator, overflow). Items are handled one at a time.
// After the accepting edge an item forms the products (and the cross-term sum
// for add and subtract), seeds the GCD, runs binary GCD steps (one shift or
// subtract a cycle on 64-bit magnitudes), forms the gcd, runs the restoring
// divider (64 bits for the numerator, a save, 64 for the denominator and a
// closing state) and forms the result; a zero denominator or zero numerator
// skips the GCD and divider and goes straight to forming the result. The
// result waits in an output register, and the next beat is taken only when
// that register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  logic [2:0]   s_tuser,  // operation[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // res_num[31:0], res_den[62:32], zero pad [63]
    output logic [1:0]   m_tuser   // status[1:0]
);

    rau_cmd_t    cmd_ctl, cmd_dp;
    rau_status_t stat;
    logic [31:0] res_num;
    logic [30:0] res_den;

    rau_controller u_ctl (
        .aclk, .aresetn,
        .in_valid (s_tvalid), .in_ready (s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .op_in    (s_tuser),  .stat, .cmd(cmd_ctl)
    );

    rau_sequencer u_seq (
        .aclk, .aresetn, .cmd_in(cmd_ctl), .stat, .cmd_out(cmd_dp)
    );

    rau_datapath u_dp (
        .aclk,
        .in_op   (s_tuser),
        .in_a_num(s_tdata[31:0]),
        .in_a_den(s_tdata[63:32]),
        .in_b_num(s_tdata[95:64]),
        .in_b_den(s_tdata[127:96]),
        .cmd     (cmd_dp),
        .stat,
        .res_num, .res_den,
        .res_status(m_tuser)
    );

    assign m_tdata = {1'b0, res_den, res_num};

endmodule

>>> hdl/rau_datapath.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Sign split, products, binary GCD, restoring division and result packing.
// ----------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
(
    input  logic                   aclk,
    input  logic [2:0]             in_op,
    input  logic [VALUE_WIDTH-1:0] in_a_num,
    input  logic [VALUE_WIDTH-1:0] in_a_den,
    input  logic [VALUE_WIDTH-1:0] in_b_num,
    input  logic [VALUE_WIDTH-1:0] in_b_den,
    input  rau_cmd_t               cmd,
    output rau_status_t            stat,
    output logic [31:0]            res_num,
    output logic [30:0]            res_den,
    output logic [1:0]             res_status
);

    localparam logic [MAG_WIDTH-1:0] LIMIT = MAG_WIDTH'(1) << (VALUE_WIDTH - 1);

    logic [2:0]                op_reg;
    logic [VALUE_WIDTH-1:0]    an_reg, ad_reg, bn_reg, bd_reg;
    logic                      as_reg, bs_reg, zd_reg;
    logic [MAG_WIDTH-1:0]      x_reg, y_reg, rn_reg, rd_reg;
    logic                      rneg_reg;
    logic [MAG_WIDTH-1:0]      gu_reg, gv_reg;
    logic [CNT_WIDTH-1:0]      gk_reg;
    logic [MAG_WIDTH-1:0]      g_reg;
    logic [MAG_WIDTH-1:0]      dq_reg, drem_reg, qn_reg;
    logic [CNT_WIDTH-1:0]      dcnt_reg;
    logic [31:0]               res_num_reg;
    logic [30:0]               res_den_reg;
    logic [1:0]                res_status_reg;

    function automatic logic [VALUE_WIDTH:0] split(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] m;
        m = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
        return {v[VALUE_WIDTH-1], m};
    endfunction

    logic [VALUE_WIDTH:0] san, sad, sbn, sbd;
    logic [2:0]           op_n;
    logic                 ys;
    logic [MAG_WIDTH-1:0] gu_sh, gv_sh, gdiff;
    logic [MAG_WIDTH:0]   dtrial;
    logic [MAG_WIDTH-1:0] drem_sh;

    assign san  = split(in_a_num);
    assign sad  = split(in_a_den);
    assign sbn  = split(in_b_num);
    assign sbd  = split(in_b_den);
    assign op_n = (in_op >= OP_ADD && in_op <= OP_DIV) ? in_op : OP_REDUCE;
    assign ys   = (op_reg == OP_SUB) ? !bs_reg : bs_reg;

    assign gu_sh   = gu_reg >> 1;
    assign gv_sh   = gv_reg >> 1;
    assign gdiff   = (gu_reg > gv_reg) ? gu_reg - gv_reg : gv_reg - gu_reg;
    assign drem_sh = {drem_reg[MAG_WIDTH-2:0], dq_reg[MAG_WIDTH-1]};
    assign dtrial  = {1'b0, drem_sh} - {1'b0, g_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= op_n;
            an_reg <= san[VALUE_WIDTH-1:0];
            ad_reg <= sad[VALUE_WIDTH-1:0];
            bn_reg <= sbn[VALUE_WIDTH-1:0];
            bd_reg <= sbd[VALUE_WIDTH-1:0];
            as_reg <= san[VALUE_WIDTH] ^ sad[VALUE_WIDTH];
            bs_reg <= sbn[VALUE_WIDTH] ^ sbd[VALUE_WIDTH];
            zd_reg <= (sad[VALUE_WIDTH-1:0] == '0)
                   || (op_n != OP_REDUCE && sbd[VALUE_WIDTH-1:0] == '0)
                   || (op_n == OP_DIV && sbn[VALUE_WIDTH-1:0] == '0);
        end
        if (cmd.mult) begin
            unique case (op_reg)
                OP_ADD, OP_SUB: begin
                    x_reg  <= MAG_WIDTH'(an_reg) * MAG_WIDTH'(bd_reg);
                    y_reg  <= MAG_WIDTH'(bn_reg) * MAG_WIDTH'(ad_reg);
                    rd_reg <= MAG_WIDTH'(ad_reg) * MAG_WIDTH'(bd_reg);
                end
                OP_MUL: begin
                    rn_reg <= MAG_WIDTH'(an_reg) * MAG_WIDTH'(bn_reg);
                    rd_reg <= MAG_WIDTH'(ad_reg) * MAG_WIDTH'(bd_reg);
                    rneg_reg <= as_reg ^ bs_reg;
                end
                OP_DIV: begin
                    rn_reg <= MAG_WIDTH'(an_reg) * MAG_WIDTH'(bd_reg);
                    rd_reg <= MAG_WIDTH'(ad_reg) * MAG_WIDTH'(bn_reg);
                    rneg_reg <= as_reg ^ bs_reg;
                end
                default: begin
                    rn_reg <= MAG_WIDTH'(an_reg);
                    rd_reg <= MAG_WIDTH'(ad_reg);
                    rneg_reg <= as_reg;
                end
            endcase
        end
        if (cmd.combine) begin
            if (as_reg == ys) begin
                rn_reg <= x_reg + y_reg;
                rneg_reg <= as_reg;
            end else if (x_reg >= y_reg) begin
                rn_reg <= x_reg - y_reg;
                rneg_reg <= as_reg;
            end else begin
                rn_reg <= y_reg - x_reg;
                rneg_reg <= ys;
            end
        end
        // Binary GCD: strip common twos, then subtract until one side is zero.
        if (cmd.gcd_start) begin
            gu_reg <= rn_reg;
            gv_reg <= rd_reg;
            gk_reg <= '0;
        end else if (cmd.gcd_step) begin
            priority if (!gu_reg[0] && !gv_reg[0]) begin
                gu_reg <= gu_sh;
                gv_reg <= gv_sh;
                gk_reg <= gk_reg + 1'b1;
            end else if (!gu_reg[0]) begin
                gu_reg <= gu_sh;
            end else if (!gv_reg[0]) begin
                gv_reg <= gv_sh;
            end else if (gu_reg > gv_reg) begin
                gu_reg <= gdiff;
            end else begin
                gv_reg <= gdiff;
            end
        end
        // The gcd is the odd remainder scaled back by the common twos.
        if (cmd.div_start) begin
            g_reg    <= (gu_reg | gv_reg) << gk_reg[5:0];
            dq_reg   <= rn_reg;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_save) begin
            qn_reg   <= dq_reg;
            dq_reg   <= rd_reg;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (!dtrial[MAG_WIDTH]) begin
                drem_reg <= dtrial[MAG_WIDTH-1:0];
                dq_reg   <= {dq_reg[MAG_WIDTH-2:0], 1'b1};
            end else begin
                drem_reg <= drem_sh;
                dq_reg   <= {dq_reg[MAG_WIDTH-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.finish) begin
            priority if (zd_reg) begin
                res_num_reg <= '0; res_den_reg <= '0; res_status_reg <= ST_ZERO_DEN;
            end else if (rn_reg == '0) begin
                res_num_reg <= '0; res_den_reg <= 31'd1; res_status_reg <= ST_OK;
            end else if (dq_reg >= LIMIT
                         || (rneg_reg ? (qn_reg > LIMIT) : (qn_reg >= LIMIT))) begin
                res_num_reg <= '0; res_den_reg <= '0; res_status_reg <= ST_OVERFLOW;
            end else begin
                res_num_reg <= rneg_reg ? 32'(~qn_reg + 1'b1) : qn_reg[31:0];
                res_den_reg <= dq_reg[30:0];
                res_status_reg <= ST_OK;
            end
        end
    end

    // A pass is done once all quotient bits have been shifted in.
    assign stat.zero_den = zd_reg;
    assign stat.num_zero = (rn_reg == '0);
    assign stat.gcd_done = (gu_reg == '0) || (gv_reg == '0);
    assign stat.div_done = (dcnt_reg == CNT_WIDTH'(MAG_WIDTH));
    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign res_status = res_status_reg;

endmodule

>>> hdl/rau_controller.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences one item through the datapath and runs the stream handshakes.
// ----------------------------------------------------------------------------
module rau_controller
    import rau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  op_in,
    input  rau_status_t stat,
    output rau_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MULT    = 3'd1;
    localparam logic [2:0] S_COMBINE = 3'd2;
    localparam logic [2:0] S_GCD     = 3'd3;
    localparam logic [2:0] S_DIVN    = 3'd4;
    localparam logic [2:0] S_DIVD    = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       addsub_reg, addsub_next;
    logic       out_valid_reg, out_valid_next;
    logic       pass_reg, pass_next;
    logic       busy;

    // A finished beat waits in the output register. Input is held off while
    // an item is in flight, or while that register is full and not being read.
    assign busy     = (state_reg != S_IDLE);
    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        addsub_next    = addsub_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load    = 1'b1;
                    addsub_next = (op_in == OP_ADD) || (op_in == OP_SUB);
                    state_next  = S_MULT;
                end
            end
            S_MULT: begin
                cmd.mult   = 1'b1;
                state_next = addsub_reg ? S_COMBINE : S_GCD;
            end
            S_COMBINE: begin
                cmd.combine = 1'b1;
                state_next  = S_GCD;
            end
            S_GCD: begin
                if (stat.zero_den || stat.num_zero) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.gcd_start = 1'b1;
                    state_next    = S_DIVN;
                end
            end
            S_DIVN: begin
                if (!stat.gcd_done) begin
                    cmd.gcd_step = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVD;
                end
            end
            S_DIVD: begin
                // At the end of the first pass the step is turned into a save
                // by the sequencer; the end of the second pass leaves for finish.
                if (!stat.div_done || !pass_reg) begin
                    cmd.div_step = 1'b1;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The divider runs twice: numerator, then denominator.
    always_comb begin
        pass_next = pass_reg;
        if (cmd.div_start) begin
            pass_next = 1'b0;
        end else if (state_reg == S_DIVD && stat.div_done && !pass_reg) begin
            pass_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            addsub_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addsub_reg    <= addsub_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
        end
    end

endmodule

>>> hdl/rau_sequencer.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit command shaping
// Turns the end of the first division pass into a save of the quotient.
// ----------------------------------------------------------------------------
module rau_sequencer
    import rau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rau_cmd_t    cmd_in,
    input  rau_status_t stat,
    output rau_cmd_t    cmd_out
);

    logic pass_reg, pass_next;

    // Counts division passes: the first ends in a save, the second in finish.
    always_comb begin
        pass_next = pass_reg;
        cmd_out   = cmd_in;
        if (cmd_in.div_start) begin
            pass_next = 1'b0;
        end else if (cmd_in.div_step && stat.div_done && !pass_reg) begin
            cmd_out.div_step = 1'b0;
            cmd_out.div_save = 1'b1;
            pass_next        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_reg <= 1'b0;
        end else begin
            pass_reg <= pass_next;
        end
    end

endmodule

>>> hdl/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks of the unit's sequencing and result encoding.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rau_checker
    import rau_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `RAU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `RAU_ASSERT_IMPL(a_status_code, aclk, aresetn, m_tvalid, m_tuser != 2'd3, "unknown status code")
    `RAU_ASSERT_IMPL(a_error_zero, aclk, aresetn, m_tvalid && m_tuser != ST_OK, m_tdata == '0, "error beat not cleared")
    `RAU_ASSERT_IMPL(a_ok_den, aclk, aresetn, m_tvalid && m_tuser == ST_OK, m_tdata[62:32] != '0, "zero denominator on ok beat")
    `RAU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
